@@ rtl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, widths and op codes shared by the compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int CFG_W   = 48;
    localparam int IDX_W   = 2;
    localparam int WORD_W  = 64;
    localparam int READ_W  = 33;

    localparam logic [IDX_W-1:0] REG_TEMP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PFIRST = 2'd1;
    localparam logic [IDX_W-1:0] REG_PMID   = 2'd2;
    localparam logic [IDX_W-1:0] REG_PLAST  = 2'd3;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] msb_byte;
        logic [7:0] lsb_byte;
        logic [7:0] xlsb_byte;
    } in_beat_t;

    typedef struct packed {
        logic signed [READ_W-1:0] reading;
        logic                     divide_guard;
    } out_beat_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

endpackage

@@ rtl/pressure_temperature_compensation_top.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Integer temperature and pressure compensation of a barometric sensor reading.
// ----------------------------------------------------------------------------
// channel | ports            | direction
// input   | s_valid/s_ready  | command and raw bytes in
// result  | m_valid/m_ready  | reading and divide guard out
// configuration writes on cfg_we/cfg_index/cfg_data, no wait
// each step of the shared multiplier, and the divide, holds the sequencer until it is done
// temperature result valid after acceptance and 4 products
// pressure result valid after acceptance, 10 products and the divide, or earlier,
// without the divide, when the divisor is zero
// s_ready is low from acceptance until the result beat is taken, high the cycle after
// synchronous active-low reset clears the sequencer, calibration and fine temperature
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ptc_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ptc_pkg::out_beat_t             m_data,
    input  logic                           cfg_we,
    input  logic [ptc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0]      cfg_data
);
    localparam int W = ptc_pkg::WORD_W;

    localparam logic [W-1:0] TF_OFFSET = 64'd128000;
    localparam logic [W-1:0] ADC_SPAN  = 64'd1048576;
    localparam logic [W-1:0] P_SCALE   = 64'd3125;
    localparam logic [W-1:0] T_ROUND   = 64'd128;
    localparam logic [W-1:0] T_SCALE   = 64'd5;
    localparam logic [W-1:0] V1_BIAS   = 64'h0000_8000_0000_0000;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T1   = 5'd1;  // d1*t2
    localparam logic [4:0] S_T2   = 5'd2;  // d2*d2
    localparam logic [4:0] S_T3   = 5'd3;  // (..>>12)*t3
    localparam logic [4:0] S_T4   = 5'd4;  // tf*5
    localparam logic [4:0] S_P1   = 5'd5;  // v1*v1
    localparam logic [4:0] S_P2   = 5'd6;  // sq*p6
    localparam logic [4:0] S_P3   = 5'd7;  // v1*p5
    localparam logic [4:0] S_P4   = 5'd8;  // sq*p3
    localparam logic [4:0] S_P5   = 5'd9;  // v1*p2
    localparam logic [4:0] S_P6   = 5'd10; // (2^47+v1)*p1
    localparam logic [4:0] S_P7   = 5'd11; // num*3125
    localparam logic [4:0] S_P8   = 5'd12; // divide
    localparam logic [4:0] S_P9   = 5'd13; // p9*h
    localparam logic [4:0] S_P10  = 5'd14; // *h
    localparam logic [4:0] S_P11  = 5'd15; // p8*p
    localparam logic [4:0] S_OUT  = 5'd16;

    logic [ptc_pkg::CFG_W-1:0] tcal_reg, pc1_reg, pc2_reg, pc3_reg;
    logic [31:0]  tfine_reg;
    logic [4:0]   st_reg;
    logic         wait_reg;
    logic [19:0]  adc_reg;
    logic [19:0]  adc_raw;
    logic [W-1:0] x_reg, y_reg, z_reg, sq_reg, pv_reg;
    logic [W-1:0] prod, quo, tfx, v1, tsum, pdiv, pfin;
    logic         is_mul, is_div, mstart, mdone, dstart;
    ptc_pkg::div_ctrl_t dctl;
    ptc_pkg::out_beat_t res_reg;

    function automatic logic [W-1:0] cs(input logic [ptc_pkg::CFG_W-1:0] r, input int k);
        cs = W'($signed(r[16*k +: 16]));
    endfunction
    function automatic logic [W-1:0] cu(input logic [ptc_pkg::CFG_W-1:0] r);
        cu = W'(r[15:0]);
    endfunction
    function automatic logic [W-1:0] asr(input logic [W-1:0] v, input int n);
        asr = W'($signed(v) >>> n);
    endfunction

    assign adc_raw = {s_data.msb_byte, s_data.lsb_byte, s_data.xlsb_byte[7:4]};
    assign tfx     = W'($signed(tfine_reg));
    assign v1      = tfx - TF_OFFSET;
    assign tsum    = z_reg + asr(prod, 14);
    assign pdiv    = asr(prod, 33);
    assign pfin    = asr(z_reg + pv_reg + asr(prod, 19), 8) + (cs(pc3_reg, 0) << 4);

    ptc_mul u_mul (.aclk(aclk), .aresetn(aresetn), .start(mstart), .a(x_reg), .b(y_reg),
        .done(mdone), .product(prod));
    ptc_divider u_div (.aclk(aclk), .aresetn(aresetn), .start(dstart), .dividend(z_reg),
        .divisor(pv_reg), .ctrl(dctl), .quotient(quo));

    assign is_div  = st_reg == S_P8;
    assign is_mul  = st_reg != S_IDLE && st_reg != S_OUT && !is_div;
    assign mstart  = is_mul && !wait_reg;
    assign dstart  = is_div && !wait_reg;
    assign s_ready = st_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcal_reg <= '0; pc1_reg <= '0; pc2_reg <= '0; pc3_reg <= '0;
            tfine_reg <= '0; st_reg <= S_IDLE; wait_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ptc_pkg::REG_TEMP:   tcal_reg <= cfg_data;
                    ptc_pkg::REG_PFIRST: pc1_reg  <= cfg_data;
                    ptc_pkg::REG_PMID:   pc2_reg  <= cfg_data;
                    ptc_pkg::REG_PLAST:  pc3_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (mstart || dstart) begin
                wait_reg <= 1'b1;
            end else if (mdone || dctl.done) begin
                wait_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    adc_reg <= adc_raw;
                    if (s_data.command == ptc_pkg::CMD_TEMP) begin
                        x_reg <= W'(adc_raw >> 3) - (cu(tcal_reg) << 1);
                        y_reg <= cs(tcal_reg, 1);
                        st_reg <= S_T1;
                    end else begin
                        x_reg <= v1;
                        y_reg <= v1;
                        st_reg <= S_P1;
                    end
                end
                S_T1: if (mdone) begin
                    z_reg <= asr(prod, 11);
                    x_reg <= W'(adc_reg >> 4) - cu(tcal_reg);
                    y_reg <= W'(adc_reg >> 4) - cu(tcal_reg);
                    st_reg <= S_T2;
                end
                S_T2: if (mdone) begin
                    x_reg <= asr(prod, 12); y_reg <= cs(tcal_reg, 2);
                    st_reg <= S_T3;
                end
                S_T3: if (mdone) begin
                    tfine_reg <= tsum[31:0];
                    x_reg <= W'($signed(tsum[31:0]));
                    y_reg <= T_SCALE;
                    st_reg <= S_T4;
                end
                S_T4: if (mdone) begin
                    res_reg.reading <= ptc_pkg::READ_W'(asr(prod + T_ROUND, 8));
                    res_reg.divide_guard <= 1'b0;
                    st_reg <= S_OUT;
                end
                S_P1: if (mdone) begin
                    sq_reg <= prod; x_reg <= prod; y_reg <= cs(pc2_reg, 2);
                    st_reg <= S_P2;
                end
                S_P2: if (mdone) begin
                    z_reg <= prod; x_reg <= v1; y_reg <= cs(pc2_reg, 1);
                    st_reg <= S_P3;
                end
                S_P3: if (mdone) begin
                    z_reg <= z_reg + (prod << 17) + (cs(pc2_reg, 0) << 35);
                    x_reg <= sq_reg; y_reg <= cs(pc1_reg, 2);
                    st_reg <= S_P4;
                end
                S_P4: if (mdone) begin
                    pv_reg <= asr(prod, 8); x_reg <= v1; y_reg <= cs(pc1_reg, 1);
                    st_reg <= S_P5;
                end
                S_P5: if (mdone) begin
                    x_reg <= V1_BIAS + pv_reg + (prod << 12);
                    y_reg <= cu(pc1_reg);
                    st_reg <= S_P6;
                end
                S_P6: if (mdone) begin
                    if (pdiv == '0) begin
                        res_reg.reading <= '0; res_reg.divide_guard <= 1'b1;
                        st_reg <= S_OUT;
                    end else begin
                        pv_reg <= pdiv;
                        x_reg <= ((ADC_SPAN - W'(adc_reg)) << 31) - z_reg;
                        y_reg <= P_SCALE;
                        st_reg <= S_P7;
                    end
                end
                S_P7: if (mdone) begin
                    z_reg <= prod;
                    st_reg <= S_P8;
                end
                S_P8: if (dctl.done) begin
                    z_reg <= quo;
                    x_reg <= cs(pc3_reg, 2); y_reg <= asr(quo, 13);
                    st_reg <= S_P9;
                end
                S_P9: if (mdone) begin
                    x_reg <= prod; y_reg <= asr(z_reg, 13);
                    st_reg <= S_P10;
                end
                S_P10: if (mdone) begin
                    pv_reg <= asr(prod, 25);
                    x_reg <= cs(pc3_reg, 1); y_reg <= z_reg;
                    st_reg <= S_P11;
                end
                S_P11: if (mdone) begin
                    res_reg.reading <= {1'b0, pfin[31:0]};
                    res_reg.divide_guard <= 1'b0;
                    st_reg <= S_OUT;
                end
                S_OUT: if (m_ready) begin
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = st_reg == S_OUT;
    assign m_data  = res_reg;
endmodule

@@ rtl/ptc_divider.sv @@
// ----------------------------------------------------------------------------
// ptc_divider
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module ptc_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ptc_pkg::WORD_W-1:0]   dividend,
    input  logic [ptc_pkg::WORD_W-1:0]   divisor,
    output ptc_pkg::div_ctrl_t           ctrl,
    output logic [ptc_pkg::WORD_W-1:0]   quotient
);
    localparam int W = ptc_pkg::WORD_W;

    logic [W-1:0]   q_reg, q_next, d_reg, d_next;
    logic [W:0]     r_reg, r_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic           neg_reg, neg_next, busy_reg, busy_next, done_reg, done_next;
    logic [W:0]     trial;
    logic [W:0]     diff;

    always_comb begin
        trial = {r_reg[W-1:0], q_reg[W-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_comb begin
        q_next = q_reg; d_next = d_reg; r_next = r_reg; cnt_next = cnt_reg;
        neg_next = neg_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            q_next    = dividend[W-1] ? (W'(0) - dividend) : dividend;
            d_next    = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            r_next    = '0;
            cnt_next  = 7'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                r_next = diff;
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign ctrl.done  = done_reg;
    assign quotient   = neg_reg ? (W'(0) - q_reg) : q_reg;
endmodule

@@ rtl/ptc_mul.sv @@
// ----------------------------------------------------------------------------
// ptc_mul
// Shared 64x64 wrapping multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
module ptc_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ptc_pkg::WORD_W-1:0]   a,
    input  logic [ptc_pkg::WORD_W-1:0]   b,
    output logic                         done,
    output logic [ptc_pkg::WORD_W-1:0]   product
);
    localparam int W = ptc_pkg::WORD_W;
    localparam int H = W / 2;

    logic [W-1:0] a_reg, b_reg, acc_reg, acc_next, pp_reg;
    logic [1:0]   ph_reg, ph_next;
    logic         busy_reg, busy_next, done_reg, done_next;
    logic [H-1:0] op_x, op_y;

    always_comb begin
        case (ph_reg)
            2'd0: begin op_x = a_reg[H-1:0]; op_y = b_reg[H-1:0]; end
            2'd1: begin op_x = a_reg[W-1:H]; op_y = b_reg[H-1:0]; end
            2'd2: begin op_x = a_reg[H-1:0]; op_y = b_reg[W-1:H]; end
            default: begin op_x = '0; op_y = '0; end
        endcase
    end

    always_comb begin
        acc_next = acc_reg; ph_next = ph_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            acc_next = '0; ph_next = 2'd0; busy_next = 1'b1;
        end else if (busy_reg) begin
            ph_next = ph_reg + 2'd1;
            case (ph_reg)
                2'd1: acc_next = acc_reg + pp_reg;
                2'd2: acc_next = acc_reg + {pp_reg[H-1:0], {H{1'b0}}};
                2'd3: begin
                    acc_next  = acc_reg + {pp_reg[H-1:0], {H{1'b0}}};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; ph_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; ph_reg <= ph_next;
        end
        if (start) begin
            a_reg <= a; b_reg <= b;
        end
        pp_reg  <= W'(op_x) * W'(op_y);
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

@@ tb/pressure_temperature_compensation_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top_tb
// Drives command and raw byte beats through the compensation block under
// several calibration settings and random stalls on both channels. Each
// accepted input beat is run through an in-bench integer compensation; every
// result beat is compared field by field with the oldest predicted reading.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top_tb;

    class comp_scoreboard;
        logic [ptc_pkg::CFG_W-1:0] calib [4];
        logic [31:0] fine_temp;
        ptc_pkg::out_beat_t expected_readings [$];
        int errors;

        function new();
            for (int i = 0; i < 4; i++) calib[i] = '0;
            fine_temp = '0;
            errors = 0;
        endfunction

        function logic [63:0] asr(logic [63:0] x, int n);
            logic signed [63:0] s;
            s = x;
            return s >>> n;
        endfunction

        function logic [63:0] coef_s(logic [ptc_pkg::CFG_W-1:0] r, int k);
            logic [15:0] v;
            v = r[16*k +: 16];
            return {{48{v[15]}}, v};
        endfunction

        function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
            logic [63:0] ma, mb, q;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        function ptc_pkg::out_beat_t compensate(ptc_pkg::in_beat_t b);
            ptc_pkg::out_beat_t r;
            logic [63:0] adc, tf, t1, t2, t3, d1, d2, v1, v2, p, h, pa, pb;
            logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            adc = {44'd0, b.msb_byte, b.lsb_byte, b.xlsb_byte[7:4]};
            tf = {{32{fine_temp[31]}}, fine_temp};
            r.divide_guard = 1'b0;
            if (b.command == ptc_pkg::CMD_TEMP) begin
                t1 = {48'd0, calib[ptc_pkg::REG_TEMP][15:0]};
                t2 = coef_s(calib[ptc_pkg::REG_TEMP], 1);
                t3 = coef_s(calib[ptc_pkg::REG_TEMP], 2);
                d1 = (adc >> 3) - (t1 << 1);
                v1 = asr(d1 * t2, 11);
                d2 = (adc >> 4) - t1;
                v2 = asr(asr(d2 * d2, 12) * t3, 14);
                fine_temp = v1[31:0] + v2[31:0];
                tf = {{32{fine_temp[31]}}, fine_temp};
                p = asr(tf * 64'd5 + 64'd128, 8);
                r.reading = p[32:0];
                return r;
            end
            p1 = {48'd0, calib[ptc_pkg::REG_PFIRST][15:0]};
            p2 = coef_s(calib[ptc_pkg::REG_PFIRST], 1);
            p3 = coef_s(calib[ptc_pkg::REG_PFIRST], 2);
            p4 = coef_s(calib[ptc_pkg::REG_PMID], 0);
            p5 = coef_s(calib[ptc_pkg::REG_PMID], 1);
            p6 = coef_s(calib[ptc_pkg::REG_PMID], 2);
            p7 = coef_s(calib[ptc_pkg::REG_PLAST], 0);
            p8 = coef_s(calib[ptc_pkg::REG_PLAST], 1);
            p9 = coef_s(calib[ptc_pkg::REG_PLAST], 2);
            v1 = tf - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = asr(((64'd1 << 47) + v1) * p1, 33);
            if (v1 == 64'd0) begin
                r.reading = '0;
                r.divide_guard = 1'b1;
                return r;
            end
            p = 64'd1048576 - adc;
            p = sdiv(((p << 31) - v2) * 64'd3125, v1);
            h = asr(p, 13);
            pa = asr(p9 * h * h, 25);
            pb = asr(p8 * p, 19);
            p = asr(p + pa + pb, 8) + (p7 << 4);
            r.reading = {1'b0, p[31:0]};
            return r;
        endfunction

        function void note_input(ptc_pkg::in_beat_t b);
            expected_readings.push_back(compensate(b));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(ptc_pkg::out_beat_t got);
            ptc_pkg::out_beat_t want;
            if (expected_readings.size() == 0) begin
                report("unexpected beat", {30'd0, got}, 64'd0);
            end else begin
                want = expected_readings.pop_front();
                if (got.reading !== want.reading)
                    report("reading", {31'd0, got.reading}, {31'd0, want.reading});
                if (got.divide_guard !== want.divide_guard)
                    report("divide_guard", {63'd0, got.divide_guard},
                           {63'd0, want.divide_guard});
            end
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ptc_pkg::in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ptc_pkg::out_beat_t m_data;
    logic cfg_we = 1'b0;
    logic [ptc_pkg::IDX_W-1:0] cfg_index = '0;
    logic [ptc_pkg::CFG_W-1:0] cfg_data = '0;

    comp_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int beats_moved = 0;

    localparam int WATCHDOG_LIMIT = 20000;

    always #5 aclk = ~aclk;

    pressure_temperature_compensation_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function bit idle_now();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready = 1'b0;
                repeat (600) @(negedge aclk);
            end
            m_ready = !idle_now();
        end
    end

    // result beats sampled at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
            beats_moved++;
        end
    end

    int last_moved = 0;
    always @(posedge aclk) begin
        if (beats_moved != last_moved) begin
            last_moved <= beats_moved;
        end
    end

    int quiet = 0;
    always @(posedge aclk) begin
        if (beats_moved != last_moved || !aresetn) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task send_beat(logic cmd, logic [7:0] msb, logic [7:0] lsb, logic [7:0] xlsb);
        ptc_pkg::in_beat_t b;
        b.command = cmd;
        b.msb_byte = msb;
        b.lsb_byte = lsb;
        b.xlsb_byte = xlsb;
        @(negedge aclk);
        while (idle_now()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = b;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sb.note_input(b);
        beats_moved++;
    endtask

    task send_random(logic cmd);
        send_beat(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_readings.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task write_reg(logic [ptc_pkg::IDX_W-1:0] idx, logic [ptc_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.calib[idx] = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function logic [ptc_pkg::CFG_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task set_typical();
        write_reg(ptc_pkg::REG_TEMP, {16'hFC18, 16'd26435, 16'd27504});
        write_reg(ptc_pkg::REG_PFIRST, {16'd3024, 16'hD643, 16'd36477});
        write_reg(ptc_pkg::REG_PMID, {16'hFFF9, 16'd140, 16'd2855});
        write_reg(ptc_pkg::REG_PLAST, {16'd6000, 16'hC6F8, 16'd15500});
    endtask

    task random_phase(int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 70) begin
                send_random(ptc_pkg::CMD_TEMP);
                send_random(ptc_pkg::CMD_PRESS);
                n += 2;
            end else begin
                send_random(1'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // pressure before any temperature, with all-zero calibration
        send_beat(ptc_pkg::CMD_PRESS, 8'h80, 8'h00, 8'h00);
        send_beat(ptc_pkg::CMD_TEMP, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ptc_pkg::CMD_PRESS, 8'h00, 8'h00, 8'h00);
        drain();

        set_typical();
        drain();
        send_beat(ptc_pkg::CMD_PRESS, 8'h65, 8'h5A, 8'hC0);
        send_beat(ptc_pkg::CMD_TEMP, 8'h7E, 8'hED, 8'h00);
        send_beat(ptc_pkg::CMD_TEMP, 8'h7E, 8'hED, 8'h0F);
        send_beat(ptc_pkg::CMD_PRESS, 8'h65, 8'h5A, 8'hC0);
        send_beat(ptc_pkg::CMD_PRESS, 8'h65, 8'h5A, 8'hCF);
        send_beat(ptc_pkg::CMD_TEMP, 8'h00, 8'h00, 8'h00);
        send_beat(ptc_pkg::CMD_PRESS, 8'h00, 8'h00, 8'h00);
        send_beat(ptc_pkg::CMD_PRESS, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ptc_pkg::CMD_TEMP, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ptc_pkg::CMD_PRESS, 8'hFF, 8'hFF, 8'hF0);
        send_beat(ptc_pkg::CMD_PRESS, 8'h00, 8'h00, 8'h0F);
        drain();

        // divisor forced to zero by an empty first pressure coefficient
        write_reg(ptc_pkg::REG_PFIRST, {16'd3024, 16'hD643, 16'd0});
        drain();
        send_beat(ptc_pkg::CMD_TEMP, 8'h80, 8'h00, 8'h00);
        send_beat(ptc_pkg::CMD_PRESS, 8'h80, 8'h00, 8'h00);
        drain();

        for (int i = 0; i < 4; i++) write_reg(i[ptc_pkg::IDX_W-1:0], '1);
        drain();
        send_beat(ptc_pkg::CMD_TEMP, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ptc_pkg::CMD_PRESS, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ptc_pkg::CMD_TEMP, 8'h00, 8'h00, 8'h00);
        send_beat(ptc_pkg::CMD_PRESS, 8'h00, 8'h00, 8'h00);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0 || ph == 4) begin
                set_typical();
            end else begin
                for (int i = 0; i < 4; i++) write_reg(i[ptc_pkg::IDX_W-1:0], rand48());
                if (ph == 5) write_reg(ptc_pkg::REG_PFIRST, rand48() & 48'hFFFF_FFFF_0000);
            end
            drain();
            calm = (ph == 1);
            if (ph == 2) hold_req = 1'b1;
            random_phase(70);
            if (ph == 3) drain();
            random_phase(70);
            drain();
            calm = 1'b0;
        end

        repeat (200) @(negedge aclk);
        if (sb.expected_readings.size() != 0) begin
            sb.report("readings never arrived", 64'(sb.expected_readings.size()), 64'd0);
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
